FILE: rtl/psk_iq_ramp_shaper_macros.svh
// ----------------------------------------------------------------------------
// psk_iq_ramp_shaper_macros.svh
// Assertion macros for the PSK I/Q ramp shaper.
// ----------------------------------------------------------------------------
`ifndef PSK_IQ_RAMP_SHAPER_MACROS_SVH
`define PSK_IQ_RAMP_SHAPER_MACROS_SVH

`ifndef SYNTH
`define PIRS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PIRS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define PIRS_ASSERT(label, clk, rst_n, prop, msg)
`define PIRS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

FILE: rtl/pirs_pkg.sv
// ----------------------------------------------------------------------------
// PSK I/Q ramp shaper package
// Constants, shape and phase codes, the symbol transition table and the
// quarter-wave cosine table of the shaper.
// ----------------------------------------------------------------------------
package pirs_pkg;

    localparam int COS_TABLE_SIZE = 512;
    localparam int MAX_RAMP       = 4096;
    localparam int MIN_RAMP       = 16;
    localparam int AMPLITUDE      = 22000;
    localparam int RESET_RAMP     = 256;

    localparam int RAMP_W    = 13;
    localparam int POS_W     = 12;
    localparam int LEVEL_W   = 16;
    localparam int MAG_W     = 15;
    localparam int COS_IDX_W = $clog2(COS_TABLE_SIZE);
    localparam int QTR_W     = COS_IDX_W - 2;
    localparam int QIDX_W    = COS_IDX_W - 1;
    localparam int QTR_ENTRIES = COS_TABLE_SIZE / 4 + 1;
    localparam int DVD_W     = POS_W + $clog2(COS_TABLE_SIZE / 2);
    localparam int CNT_W     = $clog2(DVD_W);

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef logic [2:0] shape_t;
    typedef logic [2:0] phase_t;
    typedef logic [2:0] symbol_t;

    localparam shape_t SH_Z  = 3'd0;
    localparam shape_t SH_P  = 3'd1;
    localparam shape_t SH_M  = 3'd2;
    localparam shape_t SH_PM = 3'd3;
    localparam shape_t SH_MP = 3'd4;
    localparam shape_t SH_PZ = 3'd5;
    localparam shape_t SH_MZ = 3'd6;
    localparam shape_t SH_ZP = 3'd7;

    localparam phase_t PH_0   = 3'd0;
    localparam phase_t PH_90  = 3'd1;
    localparam phase_t PH_180 = 3'd2;
    localparam phase_t PH_270 = 3'd3;
    localparam phase_t PH_OFF = 3'd4;

    localparam symbol_t SYM_HOLD  = 3'd0;
    localparam symbol_t SYM_P90   = 3'd1;
    localparam symbol_t SYM_180   = 3'd2;
    localparam symbol_t SYM_M90   = 3'd3;
    localparam symbol_t SYM_OFF   = 3'd4;
    localparam symbol_t SYM_ON    = 3'd5;

    typedef struct packed {
        shape_t ish;
        shape_t qsh;
        phase_t nxt;
    } trans_t;

    typedef logic [MAG_W-1:0] qcos_tab_t [QTR_ENTRIES];

    function automatic trans_t mk(shape_t i, shape_t q, phase_t n);
        trans_t t;
        t.ish = i;
        t.qsh = q;
        t.nxt = n;
        return t;
    endfunction

    function automatic trans_t trans_lookup(symbol_t sym, phase_t ph);
        trans_t t;
        t = mk(SH_Z, SH_Z, PH_OFF);
        unique case (sym)
            SYM_P90: begin
                unique case (ph)
                    PH_0:    t = mk(SH_PM, SH_P,  PH_90);
                    PH_90:   t = mk(SH_M,  SH_PM, PH_180);
                    PH_180:  t = mk(SH_MP, SH_M,  PH_270);
                    PH_270:  t = mk(SH_P,  SH_MP, PH_0);
                    default: t = mk(SH_ZP, SH_ZP, PH_0);
                endcase
            end
            SYM_180: begin
                unique case (ph)
                    PH_0:    t = mk(SH_PM, SH_PM, PH_180);
                    PH_90:   t = mk(SH_MP, SH_PM, PH_270);
                    PH_180:  t = mk(SH_MP, SH_MP, PH_0);
                    PH_270:  t = mk(SH_PM, SH_MP, PH_90);
                    default: t = mk(SH_ZP, SH_ZP, PH_0);
                endcase
            end
            SYM_M90: begin
                unique case (ph)
                    PH_0:    t = mk(SH_P,  SH_PM, PH_270);
                    PH_90:   t = mk(SH_MP, SH_P,  PH_0);
                    PH_180:  t = mk(SH_M,  SH_MP, PH_90);
                    PH_270:  t = mk(SH_PM, SH_M,  PH_180);
                    default: t = mk(SH_ZP, SH_ZP, PH_0);
                endcase
            end
            SYM_OFF: begin
                unique case (ph)
                    PH_0:    t = mk(SH_PZ, SH_PZ, PH_OFF);
                    PH_90:   t = mk(SH_MZ, SH_PZ, PH_OFF);
                    PH_180:  t = mk(SH_MZ, SH_MZ, PH_OFF);
                    PH_270:  t = mk(SH_PZ, SH_MZ, PH_OFF);
                    default: t = mk(SH_Z,  SH_Z,  PH_OFF);
                endcase
            end
            SYM_ON: begin
                unique case (ph)
                    PH_0:    t = mk(SH_P,  SH_P,  PH_0);
                    PH_90:   t = mk(SH_MP, SH_P,  PH_0);
                    PH_180:  t = mk(SH_MP, SH_MP, PH_0);
                    PH_270:  t = mk(SH_P,  SH_MP, PH_0);
                    default: t = mk(SH_ZP, SH_ZP, PH_0);
                endcase
            end
            default: begin
                unique case (ph)
                    PH_0:    t = mk(SH_P,  SH_P,  PH_0);
                    PH_90:   t = mk(SH_M,  SH_P,  PH_90);
                    PH_180:  t = mk(SH_M,  SH_M,  PH_180);
                    PH_270:  t = mk(SH_P,  SH_M,  PH_270);
                    default: t = mk(SH_Z,  SH_Z,  PH_OFF);
                endcase
            end
        endcase
        return t;
    endfunction

    // Fixed-point cosine over a quarter wave, evaluated at elaboration only.
    function automatic logic [MAG_W-1:0] quarter_cos(int unsigned m);
        logic [63:0] theta;
        logic [63:0] t2;
        logic [63:0] f;
        logic [63:0] x;
        logic [63:0] c;
        logic [63:0] r;
        if (m >= COS_TABLE_SIZE) begin
            return '0;
        end
        theta = (PI_HALF_Q30 * 64'(m)) / COS_TABLE_SIZE;
        t2 = (theta * theta) >> 30;
        f = Q30_ONE;
        f = Q30_ONE - (((t2 * f) >> 30) / 64'd132);
        f = Q30_ONE - (((t2 * f) >> 30) / 64'd90);
        f = Q30_ONE - (((t2 * f) >> 30) / 64'd56);
        f = Q30_ONE - (((t2 * f) >> 30) / 64'd30);
        f = Q30_ONE - (((t2 * f) >> 30) / 64'd12);
        x = ((t2 * f) >> 30) / 64'd2;
        c = (x >= Q30_ONE) ? 64'd0 : (Q30_ONE - x);
        r = (c * 64'(AMPLITUDE) + (Q30_ONE >> 1)) >> 30;
        return r[MAG_W-1:0];
    endfunction

    function automatic qcos_tab_t build_qcos();
        qcos_tab_t t;
        for (int j = 0; j < QTR_ENTRIES; j++) begin
            t[j] = quarter_cos(4 * j);
        end
        return t;
    endfunction

    localparam qcos_tab_t QCOS_TAB = build_qcos();

    function automatic logic signed [LEVEL_W-1:0] shape_level(
        shape_t                     shape,
        logic signed [LEVEL_W-1:0]  c,
        logic                       first_half
    );
        logic signed [LEVEL_W-1:0] amp;
        amp = LEVEL_W'(AMPLITUDE);
        unique case (shape)
            SH_P:    return amp;
            SH_M:    return -amp;
            SH_PM:   return c;
            SH_MP:   return -c;
            SH_PZ:   return first_half ? c : '0;
            SH_MZ:   return first_half ? -c : '0;
            SH_ZP:   return first_half ? '0 : -c;
            default: return '0;
        endcase
    endfunction

endpackage

FILE: rtl/psk_iq_ramp_shaper.sv
// ----------------------------------------------------------------------------
// PSK I/Q ramp shaper
// Differential-phase PSK baseband shaper with raised-cosine phase ramps.
// ----------------------------------------------------------------------------
// Each input word on the s_ channel is one sample tick and carries the symbol
// for the next period. Each tick yields one output word on the m_ channel with
// the I and Q levels for that sample, the phase after the tick, and m_tlast
// set when the tick ended a symbol period and consumed the symbol.
// The ramp position is divided by the period length in a restoring divider
// that retires one quotient bit per cycle. The ST_COS state then reads the
// cosine table into a register, and ST_FIN forms the I and Q levels. The
// block takes one word at a time; s_tready is low while a tick is in
// progress.
// The output word sits in a register; while the receiver stalls it holds,
// and a finished tick waits until the register is free.
// cfg_we writes the period length (samples per symbol) from cfg_wdata; write
// it only while the block is idle. Values outside 16 to 4096 are clamped.
// Reset sets the period to 256, the carrier off, both shapes to zero and the
// ramp position to zero.
// ----------------------------------------------------------------------------
`include "psk_iq_ramp_shaper_macros.svh"

module psk_iq_ramp_shaper
    import pirs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [RAMP_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [2:0] next_symbol
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // [15:0] i_level, [31:16] q_level, [34:32] phase_now
    output logic              m_tlast    // symbol_taken
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_COS  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [RAMP_W-1:0]          ramp_size_reg;
    phase_t                     phase_reg, phase_next;
    shape_t                     i_shape_reg, i_shape_next;
    shape_t                     q_shape_reg, q_shape_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    symbol_t                    sym_reg;
    logic [DVD_W-1:0]           dvd_reg, dvd_next;
    logic [RAMP_W-1:0]          rem_reg, rem_next;
    logic [COS_IDX_W-1:0]       quo_reg, quo_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic signed [LEVEL_W-1:0]  cos_reg;
    logic                       m_valid_reg;
    logic [39:0]                m_data_reg;
    logic                       m_last_reg;

    logic [RAMP_W-1:0]          eff_ramp;
    logic [RAMP_W:0]            rem_sh;
    logic                       q_bit;
    logic [1:0]                 quad;
    logic [QTR_W-1:0]           qlow;
    logic [QIDX_W-1:0]          qidx;
    logic signed [LEVEL_W-1:0]  qmag;
    logic                       accept;
    logic                       fire;
    logic [RAMP_W-1:0]          pos_inc;
    logic                       wrap;
    logic                       first_half;
    logic signed [LEVEL_W-1:0]  i_lvl, q_lvl;
    phase_t                     ph_cur;
    symbol_t                    sym_eff;
    trans_t                     tr;

    always_comb begin
        priority if (ramp_size_reg < RAMP_W'(MIN_RAMP)) begin
            eff_ramp = RAMP_W'(MIN_RAMP);
        end else if (ramp_size_reg > RAMP_W'(MAX_RAMP)) begin
            eff_ramp = RAMP_W'(MAX_RAMP);
        end else begin
            eff_ramp = ramp_size_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == ST_FIN) && (!m_valid_reg || m_tready);

    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, eff_ramp});

    assign quad = quo_reg[COS_IDX_W-1 -: 2];
    assign qlow = quo_reg[QTR_W-1:0];
    assign qidx = quad[0] ? (QIDX_W'(COS_TABLE_SIZE / 4) - {1'b0, qlow}) : {1'b0, qlow};
    assign qmag = LEVEL_W'(QCOS_TAB[qidx]);

    assign pos_inc    = {1'b0, pos_reg} + RAMP_W'(1);
    assign wrap       = (pos_inc >= eff_ramp);
    assign first_half = ({1'b0, pos_reg} < (eff_ramp >> 1));
    assign i_lvl      = shape_level(i_shape_reg, cos_reg, first_half);
    assign q_lvl      = shape_level(q_shape_reg, cos_reg, first_half);
    assign ph_cur     = (phase_reg > PH_OFF) ? PH_OFF : phase_reg;
    assign sym_eff    = (sym_reg > SYM_ON) ? SYM_HOLD : sym_reg;
    assign tr         = trans_lookup(sym_eff, ph_cur);

    always_comb begin
        state_next   = state_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        i_shape_next = i_shape_reg;
        q_shape_next = q_shape_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    dvd_next   = {pos_reg, {(DVD_W - POS_W){1'b0}}};
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
                rem_next = q_bit ? RAMP_W'(rem_sh - {1'b0, eff_ramp}) : RAMP_W'(rem_sh);
                quo_next = {quo_reg[COS_IDX_W-2:0], q_bit};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    state_next = ST_COS;
                end
            end
            ST_COS: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (fire) begin
                    state_next = ST_IDLE;
                    if (wrap) begin
                        pos_next     = '0;
                        i_shape_next = tr.ish;
                        q_shape_next = tr.qsh;
                        phase_next   = tr.nxt;
                    end else begin
                        pos_next = pos_inc[POS_W-1:0];
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ramp_size_reg <= RAMP_W'(RESET_RAMP);
            phase_reg     <= PH_OFF;
            i_shape_reg   <= SH_Z;
            q_shape_reg   <= SH_Z;
            pos_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            i_shape_reg <= i_shape_next;
            q_shape_reg <= q_shape_next;
            pos_reg     <= pos_next;
            if (cfg_we) begin
                ramp_size_reg <= cfg_wdata;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (accept) begin
            sym_reg <= s_tdata[2:0];
        end
        if (state_reg == ST_COS) begin
            cos_reg <= (quad == 2'd1 || quad == 2'd2) ? -qmag : qmag;
        end
        if (fire) begin
            m_data_reg <= {5'd0, phase_next, q_lvl, i_lvl};
            m_last_reg <= wrap;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `PIRS_ASSERT(a_level_range, aclk, aresetn,
        !m_valid_reg || ($signed(m_data_reg[15:0]) <= 16'sd22000
        && $signed(m_data_reg[15:0]) >= -16'sd22000
        && $signed(m_data_reg[31:16]) <= 16'sd22000
        && $signed(m_data_reg[31:16]) >= -16'sd22000), "level beyond amplitude")
    `PIRS_ASSERT_NEXT(a_phase_hold, aclk, aresetn, fire && !wrap,
        phase_reg == $past(phase_reg) && m_data_reg[34:32] == $past(phase_reg),
        "phase changed inside a period")
    `PIRS_ASSERT_NEXT(a_shapes_hold, aclk, aresetn, state_reg != ST_FIN,
        i_shape_reg == $past(i_shape_reg) && q_shape_reg == $past(q_shape_reg),
        "shape changed outside a tick end")
    `PIRS_ASSERT(a_div_count, aclk, aresetn, state_reg != ST_DIV || cnt_reg < CNT_W'(DVD_W), "divider ran past its last step")

endmodule
